// File: src/gtc_pkg.sv
// ----------------------------------------------------------------------------
// gtc_pkg
// Shared types and helpers for the grouped transposed convolution plane.
// ----------------------------------------------------------------------------
package gtc_pkg;

  // operation codes, matching the func field
  typedef enum logic [1:0] {
    OP_WLOAD = 2'd0,
    OP_PLANE = 2'd1,
    OP_PIXEL = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [2:0] REG_KERNEL_W = 3'd0;
  localparam logic [2:0] REG_KERNEL_H = 3'd1;
  localparam logic [2:0] REG_STRIDE_X = 3'd2;
  localparam logic [2:0] REG_STRIDE_Y = 3'd3;
  localparam logic [2:0] REG_DIL_X    = 3'd4;
  localparam logic [2:0] REG_DIL_Y    = 3'd5;

  // one queued command beat
  typedef struct packed {
    op_t                op;
    logic signed [15:0] data_value;
    logic [6:0]         row;
    logic [6:0]         col;
    logic [3:0]         channel;
    logic [5:0]         tap;
  } item_t;

  // raw configuration registers
  typedef struct packed {
    logic [3:0] kernel_width;
    logic [3:0] kernel_height;
    logic [2:0] stride_x;
    logic [2:0] stride_y;
    logic [2:0] dilation_x;
    logic [2:0] dilation_y;
  } cfg_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FILL,
    BK_SCAT,
    BK_DRAIN,
    BK_RDWAIT
  } bk_state_t;

  // kernel size limited to 1..8
  function automatic logic [3:0] clamp_kern(input logic [3:0] v);
    if (v == 4'd0) return 4'd1;
    if (v > 4'd8) return 4'd8;
    return v;
  endfunction

  // stride or dilation limited to 1..4
  function automatic logic [2:0] clamp_step(input logic [2:0] v);
    if (v == 3'd0) return 3'd1;
    if (v > 3'd4) return 3'd4;
    return v;
  endfunction

endpackage

// File: src/gtc_front.sv
// ----------------------------------------------------------------------------
// gtc_front
// Accepts command beats, drops those with out of range addresses, and
// pushes the rest into the command queue.
// ----------------------------------------------------------------------------
module gtc_front #(
  parameter int MAX_GROUP_CHANNELS = 16,
  parameter int MAX_TAPS           = 64
) (
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic signed [15:0] in_data_value,
  input  logic [6:0]         in_row,
  input  logic [6:0]         in_col,
  input  logic [3:0]         in_channel,
  input  logic [5:0]         in_tap,
  input  logic               q_full,
  output logic               q_push,
  output gtc_pkg::item_t     q_item
);
  import gtc_pkg::*;

  logic accept;
  logic ch_ok;
  logic tap_ok;
  logic keep;

  // accept whenever the queue has room
  assign busy   = q_full;
  assign accept = start && !q_full;

  // classify: weight loads and pixels need a valid channel / tap
  assign ch_ok  = 32'(in_channel) < MAX_GROUP_CHANNELS;
  assign tap_ok = 32'(in_tap) < MAX_TAPS;

  always_comb begin
    case (op_t'(in_func))
      OP_WLOAD: keep = ch_ok && tap_ok;
      OP_PIXEL: keep = ch_ok;
      OP_PLANE: keep = 1'b1;
      OP_READ:  keep = 1'b1;
      default:  keep = 1'b0;
    endcase
  end

  assign q_push            = accept && keep;
  assign q_item.op         = op_t'(in_func);
  assign q_item.data_value = in_data_value;
  assign q_item.row        = in_row;
  assign q_item.col        = in_col;
  assign q_item.channel    = in_channel;
  assign q_item.tap        = in_tap;

endmodule

// File: src/gtc_queue.sv
// ----------------------------------------------------------------------------
// gtc_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module gtc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gtc_pkg::item_t push_item,
  input  logic           pop,
  output gtc_pkg::item_t head,
  output logic           empty,
  output logic           full
);
  import gtc_pkg::*;

  item_t      slot_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = slot_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_item;
  end

endmodule

// File: src/gtc_back.sv
// ----------------------------------------------------------------------------
// gtc_back
// Executes queued commands: weight loads, plane fill with bias, pixel
// scatter through a three stage tap pipeline, and output reads.
// ----------------------------------------------------------------------------
module gtc_back #(
  parameter int MAX_OUT_W          = 128,
  parameter int MAX_OUT_H          = 128,
  parameter int MAX_GROUP_CHANNELS = 16,
  parameter int MAX_TAPS           = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gtc_pkg::cfg_t      cfg,
  input  gtc_pkg::item_t     head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_strobe,
  output logic signed [31:0] out_value,
  output logic               out_in_range,
  output logic               out_overflow_seen
);
  import gtc_pkg::*;

  localparam int ACC_DEPTH = MAX_OUT_W * MAX_OUT_H;
  localparam int AW        = $clog2(ACC_DEPTH);
  localparam int W_DEPTH   = MAX_GROUP_CHANNELS * MAX_TAPS;
  localparam int WA_W      = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;

  // memories
  logic signed [31:0] acc_mem [ACC_DEPTH];
  logic signed [15:0] w_mem   [W_DEPTH];

  bk_state_t state_r, state_nxt;
  item_t     cur_r;

  logic [AW-1:0]      fill_cnt_r;
  logic signed [31:0] bias_r;
  logic [2:0]         kx_r, ky_r;
  logic [4:0]         offx_r, offy_r;
  logic [6:0]         k_r;
  logic [9:0]         basex_r, basey_r;
  logic               ovf_r;
  logic               rd_range_r;

  // tap pipeline
  logic               s1_v_r, s2_v_r;
  logic [AW-1:0]      s1_addr_r, s2_addr_r;
  logic signed [31:0] s2_acc_r, prod_r;
  logic signed [31:0] acc_q;
  logic signed [15:0] w_q;

  // output registers
  logic               out_strobe_r;
  logic signed [31:0] out_value_r;
  logic               out_in_range_r;
  logic               out_overflow_r;

  // clamped configuration
  logic [3:0] kw, kh;
  logic [2:0] sx, sy, dx, dy;
  assign kw = clamp_kern(cfg.kernel_width);
  assign kh = clamp_kern(cfg.kernel_height);
  assign sx = clamp_step(cfg.stride_x);
  assign sy = clamp_step(cfg.stride_y);
  assign dx = clamp_step(cfg.dilation_x);
  assign dy = clamp_step(cfg.dilation_y);

  // current tap position
  logic [10:0] oy, ox;
  logic        tap_out, tap_live, last_kx, last_tap;
  assign oy       = {1'b0, basey_r} + 11'(offy_r);
  assign ox       = {1'b0, basex_r} + 11'(offx_r);
  assign tap_out  = (32'(oy) >= MAX_OUT_H) || (32'(ox) >= MAX_OUT_W);
  assign tap_live = !tap_out && (32'(k_r) < MAX_TAPS);
  assign last_kx  = ({1'b0, kx_r} == kw - 4'd1);
  assign last_tap = last_kx && ({1'b0, ky_r} == kh - 4'd1);

  // read position of an output read
  logic rd_in;
  assign rd_in = (32'(head.row) < MAX_OUT_H) && (32'(head.col) < MAX_OUT_W);

  // saturating add in the last pipeline stage
  logic signed [32:0] sum;
  logic signed [31:0] sum_sat;
  assign sum = {s2_acc_r[31], s2_acc_r} + {prod_r[31], prod_r};
  always_comb begin
    if (sum[32] != sum[31]) sum_sat = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else sum_sat = sum[31:0];
  end

  // memory port control
  logic          acc_re, acc_we, w_we, w_re;
  logic [AW-1:0] acc_raddr, acc_waddr;
  logic [31:0]   acc_wdata;
  logic [WA_W-1:0] w_raddr, w_waddr;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    acc_re    = 1'b0;
    acc_raddr = AW'(32'(head.row) * MAX_OUT_W + 32'(head.col));
    w_we      = 1'b0;
    w_waddr   = WA_W'(32'(head.channel) * MAX_TAPS + 32'(head.tap));
    w_re      = 1'b0;
    w_raddr   = WA_W'(32'(cur_r.channel) * MAX_TAPS + 32'(k_r));
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (head.op)
            OP_WLOAD: w_we = 1'b1;
            OP_PLANE: state_nxt = BK_FILL;
            OP_PIXEL: state_nxt = BK_SCAT;
            OP_READ: begin
              acc_re    = rd_in;
              state_nxt = BK_RDWAIT;
            end
            default: state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_FILL: begin
        if (32'(fill_cnt_r) == ACC_DEPTH - 1) state_nxt = BK_IDLE;
      end
      BK_SCAT: begin
        acc_re    = tap_live;
        w_re      = tap_live;
        acc_raddr = AW'(32'(oy) * MAX_OUT_W + 32'(ox));
        if (last_tap) state_nxt = BK_DRAIN;
      end
      BK_DRAIN: begin
        if (!s1_v_r && !s2_v_r) state_nxt = BK_IDLE;
      end
      BK_RDWAIT: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // write port: plane fill or the last pipeline stage
  assign acc_we    = (state_r == BK_FILL) || s2_v_r;
  assign acc_waddr = (state_r == BK_FILL) ? fill_cnt_r : s2_addr_r;
  assign acc_wdata = (state_r == BK_FILL) ? bias_r : sum_sat;

  // accumulator store
  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
  end
  always_ff @(posedge clk) begin
    if (acc_re) acc_q <= acc_mem[acc_raddr];
  end

  // weight store
  always_ff @(posedge clk) begin
    if (w_we) w_mem[w_waddr] <= head.data_value;
  end
  always_ff @(posedge clk) begin
    if (w_re) w_q <= w_mem[w_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      ovf_r        <= 1'b0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      s1_v_r       <= (state_r == BK_SCAT) && tap_live;
      s2_v_r       <= s1_v_r;
      out_strobe_r <= (state_r == BK_RDWAIT);
      if (state_r == BK_IDLE && q_pop && head.op == OP_PLANE) ovf_r <= 1'b0;
      else if (state_r == BK_SCAT && tap_out) ovf_r <= 1'b1;
    end
  end

  // sequencing and datapath registers
  always_ff @(posedge clk) begin
    if (state_r == BK_IDLE && q_pop) begin
      cur_r      <= head;
      fill_cnt_r <= '0;
      bias_r     <= {{8{head.data_value[15]}}, head.data_value, 8'h00};
      kx_r       <= '0;
      ky_r       <= '0;
      offx_r     <= '0;
      offy_r     <= '0;
      k_r        <= '0;
      basex_r    <= 10'(head.col) * 10'(sx);
      basey_r    <= 10'(head.row) * 10'(sy);
      rd_range_r <= rd_in;
    end
    if (state_r == BK_FILL) fill_cnt_r <= fill_cnt_r + AW'(1);
    // step through the kernel row-major
    if (state_r == BK_SCAT) begin
      k_r <= k_r + 7'd1;
      if (last_kx) begin
        kx_r   <= '0;
        offx_r <= '0;
        ky_r   <= ky_r + 3'd1;
        offy_r <= offy_r + 5'(dy);
      end else begin
        kx_r   <= kx_r + 3'd1;
        offx_r <= offx_r + 5'(dx);
      end
    end
    s1_addr_r <= acc_raddr;
    s2_addr_r <= s1_addr_r;
    s2_acc_r  <= acc_q;
    prod_r    <= cur_r.data_value * w_q;
    // read result
    if (state_r == BK_RDWAIT) begin
      out_value_r    <= rd_range_r ? acc_q : 32'sd0;
      out_in_range_r <= rd_range_r;
      out_overflow_r <= ovf_r;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_value         = out_value_r;
  assign out_in_range      = out_in_range_r;
  assign out_overflow_seen = out_overflow_r;

endmodule

// File: src/grouped_transposed_conv_plane.sv
// ----------------------------------------------------------------------------
// grouped_transposed_conv_plane
// One output plane of a grouped / depthwise transposed 2-D convolution.
// ----------------------------------------------------------------------------
//  channel   ports                       handshake
//  command   start, busy, in_*           beat taken when start && !busy
//  result    out_strobe, out_*           one cycle per beat, no back-pressure
//  config    cfg_we, cfg_index, cfg_data write when cfg_we is high
//
//  weight load: written into the weight store when popped; output read: pop,
//  wait state, then a registered result; input pixel: the pop, one tap a
//  cycle through the accumulator store port, then a drain of the tap pipeline
//  plane start: the pop, then a fill of every store entry, one entry a cycle
//  reset is synchronous; the two-entry queue raises busy when full
// ----------------------------------------------------------------------------
module grouped_transposed_conv_plane #(
  parameter int MAX_OUT_W          = 128,
  parameter int MAX_OUT_H          = 128,
  parameter int MAX_GROUP_CHANNELS = 16,
  parameter int MAX_TAPS           = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic signed [15:0] in_data_value,
  input  logic [6:0]         in_row,
  input  logic [6:0]         in_col,
  input  logic [3:0]         in_channel,
  input  logic [5:0]         in_tap,
  output logic               out_strobe,
  output logic signed [31:0] out_value,
  output logic               out_in_range,
  output logic               out_overflow_seen,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [3:0]         cfg_data
);
  import gtc_pkg::*;

  cfg_t  cfg_r;
  item_t push_item, head;
  logic  push, pop, q_empty, q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kernel_width  <= 4'd3;
      cfg_r.kernel_height <= 4'd3;
      cfg_r.stride_x      <= 3'd1;
      cfg_r.stride_y      <= 3'd1;
      cfg_r.dilation_x    <= 3'd1;
      cfg_r.dilation_y    <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KERNEL_W: cfg_r.kernel_width  <= cfg_data;
        REG_KERNEL_H: cfg_r.kernel_height <= cfg_data;
        REG_STRIDE_X: cfg_r.stride_x      <= cfg_data[2:0];
        REG_STRIDE_Y: cfg_r.stride_y      <= cfg_data[2:0];
        REG_DIL_X:    cfg_r.dilation_x    <= cfg_data[2:0];
        REG_DIL_Y:    cfg_r.dilation_y    <= cfg_data[2:0];
        default:      cfg_r <= cfg_r;
      endcase
    end
  end

  gtc_front #(
    .MAX_GROUP_CHANNELS(MAX_GROUP_CHANNELS),
    .MAX_TAPS(MAX_TAPS)
  ) u_front (
    .start(start), .busy(busy),
    .in_func(in_func), .in_data_value(in_data_value),
    .in_row(in_row), .in_col(in_col),
    .in_channel(in_channel), .in_tap(in_tap),
    .q_full(q_full), .q_push(push), .q_item(push_item)
  );

  gtc_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_item(push_item),
    .pop(pop), .head(head), .empty(q_empty), .full(q_full)
  );

  gtc_back #(
    .MAX_OUT_W(MAX_OUT_W),
    .MAX_OUT_H(MAX_OUT_H),
    .MAX_GROUP_CHANNELS(MAX_GROUP_CHANNELS),
    .MAX_TAPS(MAX_TAPS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .head(head), .q_empty(q_empty), .q_pop(pop),
    .out_strobe(out_strobe), .out_value(out_value),
    .out_in_range(out_in_range), .out_overflow_seen(out_overflow_seen)
  );

endmodule

// File: src/gtc_checker.sv
// ----------------------------------------------------------------------------
// gtc_checker
// Port-level checks on the convolution plane block.
// ----------------------------------------------------------------------------
module gtc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_strobe,
  input logic signed [31:0] out_value,
  input logic               out_in_range
);

  // no result straight out of reset
  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_strobe) else $error("result right after reset");

  // reads outside the store give zero
  a_zero_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_in_range |-> out_value == 32'sd0)
    else $error("nonzero value for out of range read");

  // results never come in adjacent cycles
  a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("back to back result beats");

  // busy is low out of reset
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> !busy) else $error("busy right after reset");

endmodule

bind grouped_transposed_conv_plane gtc_checker u_gtc_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy),
  .out_strobe(out_strobe), .out_value(out_value), .out_in_range(out_in_range)
);

// File: bench/tb_grouped_transposed_conv_plane.sv
// ----------------------------------------------------------------------------
// tb_grouped_transposed_conv_plane
// Self-checking bench for the transposed convolution plane: a short directed
// table, then random command streams under several kernel, stride and
// dilation settings, every read beat checked against a behavioral predictor or a table value.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_grouped_transposed_conv_plane;
  import gtc_pkg::*;

  localparam int OUT_W    = 128;
  localparam int OUT_H    = 128;
  localparam int GRP_CH   = 16;
  localparam int TAP_N    = 64;
  localparam int IDLE_CAP = 60000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_func;
  logic signed [15:0] in_data_value;
  logic [6:0]         in_row;
  logic [6:0]         in_col;
  logic [3:0]         in_channel;
  logic [5:0]         in_tap;
  logic               out_strobe;
  logic signed [31:0] out_value;
  logic               out_in_range;
  logic               out_overflow_seen;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [3:0]         cfg_data;

  grouped_transposed_conv_plane u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_data_value(in_data_value), .in_row(in_row),
    .in_col(in_col), .in_channel(in_channel), .in_tap(in_tap),
    .out_strobe(out_strobe), .out_value(out_value), .out_in_range(out_in_range),
    .out_overflow_seen(out_overflow_seen),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // pending read results, oldest first
  typedef struct {
    logic signed [31:0] value;
    logic               in_range;
    logic               ovf;
  } readback_t;

  readback_t pending_reads[$];

  // directed stimulus row
  typedef struct {
    op_t                op;
    logic signed [15:0] data;
    logic [6:0]         row;
    logic [6:0]         col;
    logic [3:0]         ch;
    logic [5:0]         tap;
    bit                 typed;
    logic signed [31:0] typed_value;
    logic               typed_ovf;
  } drow_t;

  // predictor state
  logic [3:0]         raw_kw, raw_kh;
  logic [2:0]         raw_sx, raw_sy, raw_dx, raw_dy;
  logic signed [15:0] weights [GRP_CH][TAP_N];
  bit                 weight_valid [GRP_CH][TAP_N];
  logic signed [31:0] accum [OUT_H*OUT_W];
  logic               ovf_flag;
  bit                 plane_started;

  int error_count;
  int beats_sent;
  int reads_checked;
  int pixels_sent;
  int settings_run;
  int idle_cycles;
  int burst_left;
  bit steady;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int kern_eff(input logic [3:0] v);
    return (v == 0) ? 1 : ((v > 8) ? 8 : int'(v));
  endfunction

  function automatic int step_eff(input logic [2:0] v);
    return (v == 0) ? 1 : ((v > 4) ? 4 : int'(v));
  endfunction

  // true when every tap of the current kernel is loaded for the channel
  function automatic bit channel_ready(input int ch);
    int n;
    n = kern_eff(raw_kw) * kern_eff(raw_kh);
    for (int k = 0; k < n; k++) if (!weight_valid[ch][k]) return 1'b0;
    return 1'b1;
  endfunction

  // scatter one pixel through the kernel with saturating accumulation
  task automatic scatter(input logic signed [15:0] pix, input int r, input int c,
                         input int ch);
    int kw, kh, sx, sy, dx, dy, oy, ox, k;
    longint sum;
    kw = kern_eff(raw_kw); kh = kern_eff(raw_kh);
    sx = step_eff(raw_sx); sy = step_eff(raw_sy);
    dx = step_eff(raw_dx); dy = step_eff(raw_dy);
    for (int ky = 0; ky < kh; ky++) begin
      for (int kx = 0; kx < kw; kx++) begin
        k  = ky * kw + kx;
        oy = r * sy + ky * dy;
        ox = c * sx + kx * dx;
        if (oy >= OUT_H || ox >= OUT_W) begin
          ovf_flag = 1'b1;
        end else if (k < TAP_N) begin
          sum = longint'(accum[oy*OUT_W+ox]) + longint'(pix) * longint'(weights[ch][k]);
          if (sum > 64'sd2147483647) sum = 64'sd2147483647;
          if (sum < -64'sd2147483648) sum = -64'sd2147483648;
          accum[oy*OUT_W+ox] = sum[31:0];
        end
      end
    end
  endtask

  // advance the predictor by one accepted command beat
  task automatic predict_beat(input op_t op, input logic signed [15:0] d,
                              input logic [6:0] r, input logic [6:0] c,
                              input logic [3:0] ch, input logic [5:0] tp,
                              input bit typed, input logic signed [31:0] tv,
                              input logic tovf);
    readback_t rb;
    case (op)
      OP_WLOAD: begin
        weights[ch][tp] = d;
        weight_valid[ch][tp] = 1'b1;
      end
      OP_PLANE: begin
        for (int i = 0; i < OUT_H*OUT_W; i++) accum[i] = 32'(d) * 256;
        ovf_flag = 1'b0;
        plane_started = 1'b1;
      end
      OP_PIXEL: begin
        scatter(d, r, c, ch);
        pixels_sent++;
      end
      default: begin
        rb.value    = accum[r*OUT_W+c];
        rb.in_range = 1'b1;
        rb.ovf      = ovf_flag;
        if (typed) begin
          rb.value = tv;
          rb.ovf   = tovf;
        end
        pending_reads.push_back(rb);
      end
    endcase
  endtask

  // drive one beat, hold it until taken, then maybe open a gap
  task automatic issue(input op_t op, input logic signed [15:0] d,
                       input logic [6:0] r, input logic [6:0] c,
                       input logic [3:0] ch, input logic [5:0] tp,
                       input bit typed = 1'b0, input logic signed [31:0] tv = 0,
                       input logic tovf = 1'b0);
    start         <= 1'b1;
    in_func       <= op;
    in_data_value <= d;
    in_row        <= r;
    in_col        <= c;
    in_channel    <= ch;
    in_tap        <= tp;
    do @(posedge clk); while (busy);
    predict_beat(op, d, r, c, ch, tp, typed, tv, tovf);
    beats_sent++;
    if (!steady) begin
      if (burst_left == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // let all reads return, then allow the back end to settle
  task automatic drain_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [3:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_KERNEL_W: raw_kw = val;
      REG_KERNEL_H: raw_kh = val;
      REG_STRIDE_X: raw_sx = val[2:0];
      REG_STRIDE_Y: raw_sy = val[2:0];
      REG_DIL_X:    raw_dx = val[2:0];
      default:      raw_dy = val[2:0];
    endcase
  endtask

  task automatic apply_setting(input logic [3:0] kw, input logic [3:0] kh,
                               input logic [3:0] sx, input logic [3:0] sy,
                               input logic [3:0] dx, input logic [3:0] dy);
    write_reg(REG_KERNEL_W, kw);
    write_reg(REG_KERNEL_H, kh);
    write_reg(REG_STRIDE_X, sx);
    write_reg(REG_STRIDE_Y, sy);
    write_reg(REG_DIL_X, dx);
    write_reg(REG_DIL_Y, dy);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_data();
    case ($urandom_range(0, 5))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'($urandom_range(0, 512)) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // one random stream: plane start, kernel loads, then mixed commands
  task automatic random_stream(input int n_items);
    int ch_a, ch_b, n_taps, sel, ch, lim;
    n_taps = kern_eff(raw_kw) * kern_eff(raw_kh);
    ch_a = $urandom_range(0, GRP_CH-1);
    ch_b = $urandom_range(0, GRP_CH-1);
    issue(OP_PLANE, rand_data(), 7'($urandom), 7'($urandom), 4'($urandom), 6'($urandom));
    for (int k = 0; k < n_taps; k++) begin
      issue(OP_WLOAD, rand_data(), 7'($urandom), 7'($urandom), 4'(ch_a), 6'(k));
      issue(OP_WLOAD, rand_data(), 7'($urandom), 7'($urandom), 4'(ch_b), 6'(k));
    end
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, 99);
      lim = ($urandom_range(0, 9) == 0) ? 127 : 127 / (step_eff(raw_sx) + 1);
      if (sel < 55) begin
        ch = ($urandom_range(0, 1) == 0) ? ch_a : ch_b;
        if (!channel_ready(ch)) ch = ch_a;
        issue(OP_PIXEL, rand_data(), 7'($urandom_range(0, lim)),
              7'($urandom_range(0, lim)), 4'(ch), 6'($urandom));
      end else if (sel < 90) begin
        issue(OP_READ, 16'($urandom), 7'($urandom), 7'($urandom),
              4'($urandom), 6'($urandom));
      end else begin
        issue(OP_WLOAD, rand_data(), 7'($urandom), 7'($urandom),
              4'($urandom), 6'($urandom));
      end
    end
    // a closing read marks the end of the stream's back-end work
    issue(OP_READ, 16'($urandom), 7'($urandom), 7'($urandom), 4'($urandom), 6'($urandom));
  endtask

  function automatic drow_t mk(input op_t op, input logic signed [15:0] d,
                               input int r, input int c, input int ch, input int tp,
                               input bit typed = 1'b0,
                               input logic signed [31:0] tv = 0, input logic tovf = 0);
    drow_t x;
    x.op = op; x.data = d; x.row = 7'(r); x.col = 7'(c); x.ch = 4'(ch); x.tap = 6'(tp);
    x.typed = typed; x.typed_value = tv; x.typed_ovf = tovf;
    return x;
  endfunction

  // result checker
  always @(posedge clk) begin
    readback_t rb;
    if (rst_n && out_strobe) begin
      if (pending_reads.size() == 0) begin
        $error("read beat with nothing pending: value %0d", out_value);
        error_count++;
      end else begin
        rb = pending_reads.pop_front();
        reads_checked++;
        if (out_value !== rb.value) begin
          $error("out_value: expected %0d, got %0d", rb.value, out_value);
          error_count++;
        end
        if (out_in_range !== rb.in_range) begin
          $error("out_in_range: expected %0b, got %0b", rb.in_range, out_in_range);
          error_count++;
        end
        if (out_overflow_seen !== rb.ovf) begin
          $error("out_overflow_seen: expected %0b, got %0b", rb.ovf, out_overflow_seen);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_CAP) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    drow_t dtab[$];
    error_count = 0; beats_sent = 0; reads_checked = 0; pixels_sent = 0;
    settings_run = 0; burst_left = 0; steady = 1'b1; idle_cycles = 0;
    raw_kw = 4'd3; raw_kh = 4'd3; raw_sx = 3'd1; raw_sy = 3'd1; raw_dx = 3'd1; raw_dy = 3'd1;
    ovf_flag = 1'b0; plane_started = 1'b0;
    foreach (weight_valid[c, k]) weight_valid[c][k] = 1'b0;
    rst_n = 1'b0; start = 1'b0; in_func = '0; in_data_value = '0; in_row = '0;
    in_col = '0; in_channel = '0; in_tap = '0; cfg_we = 1'b0; cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table under the reset setting (3x3, unit stride and dilation)
    dtab.push_back(mk(OP_PLANE, 16'sh7fff, 0, 0, 0, 0));
    dtab.push_back(mk(OP_READ, 0, 127, 127, 0, 0, 1'b1, 32'sd8388352, 1'b0));
    dtab.push_back(mk(OP_WLOAD, 16'sh7fff, 0, 0, 0, 0));
    dtab.push_back(mk(OP_WLOAD, 16'sh8000, 0, 0, 0, 1));
    dtab.push_back(mk(OP_WLOAD, 16'sh0001, 0, 0, 0, 2));
    dtab.push_back(mk(OP_WLOAD, 16'shffff, 0, 0, 0, 3));
    dtab.push_back(mk(OP_WLOAD, 16'sh7fff, 0, 0, 0, 4));
    dtab.push_back(mk(OP_WLOAD, 16'sh0000, 0, 0, 0, 5));
    dtab.push_back(mk(OP_WLOAD, 16'sh0100, 0, 0, 0, 6));
    dtab.push_back(mk(OP_WLOAD, 16'sh8000, 0, 0, 0, 7));
    dtab.push_back(mk(OP_WLOAD, 16'sh7fff, 0, 0, 0, 8));
    dtab.push_back(mk(OP_READ, 0, 5, 5, 0, 0, 1'b1, 32'sd8388352, 1'b0));
    // corner pixel: most taps land outside the store
    dtab.push_back(mk(OP_PIXEL, 16'sh8000, 127, 127, 0, 0));
    dtab.push_back(mk(OP_READ, 0, 127, 127, 0, 0));
    // repeated pixel drives saturation both ways
    dtab.push_back(mk(OP_PIXEL, 16'sh7fff, 0, 0, 0, 0));
    dtab.push_back(mk(OP_PIXEL, 16'sh7fff, 0, 0, 0, 0));
    dtab.push_back(mk(OP_PIXEL, 16'sh7fff, 0, 0, 0, 0));
    dtab.push_back(mk(OP_READ, 0, 0, 0, 0, 0));
    dtab.push_back(mk(OP_READ, 0, 0, 1, 0, 0));
    dtab.push_back(mk(OP_READ, 0, 2, 2, 0, 0));
    // new plane clears the sticky flag
    dtab.push_back(mk(OP_PLANE, 16'sh8000, 0, 0, 0, 0));
    dtab.push_back(mk(OP_READ, 0, 64, 3, 0, 0, 1'b1, -32'sd8388608, 1'b0));
    foreach (dtab[i])
      issue(dtab[i].op, dtab[i].data, dtab[i].row, dtab[i].col, dtab[i].ch, dtab[i].tap,
            dtab[i].typed, dtab[i].typed_value, dtab[i].typed_ovf);
    drain_idle();

    // random streams over several settings, extremes and clamped values included
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: apply_setting(4'd3, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1);
        1: apply_setting(4'd8, 4'd8, 4'd4, 4'd4, 4'd4, 4'd4);
        2: apply_setting(4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1);
        3: apply_setting(4'd0, 4'd15, 4'd0, 4'd7, 4'd5, 4'd0);
        4: apply_setting(4'd15, 4'd0, 4'd6, 4'd0, 4'd0, 4'd7);
        default: apply_setting(4'($urandom_range(1, 8)), 4'($urandom_range(1, 8)),
                               4'($urandom_range(1, 4)), 4'($urandom_range(1, 4)),
                               4'($urandom_range(1, 4)), 4'($urandom_range(1, 4)));
      endcase
      steady = (ph == 2);
      random_stream(240);
      drain_idle();
      settings_run++;
    end

    $display("run covered %0d command beats, %0d pixels and %0d checked reads",
             beats_sent, pixels_sent, reads_checked);
    $display("over %0d register settings after the directed table", settings_run);
    if (error_count == 0 && pending_reads.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
